@@ rtl/core/ordered_set_table_assert.svh @@
// Assertion macros used by the ordered set table RTL.
`ifndef ORDERED_SET_TABLE_ASSERT_SVH
`define ORDERED_SET_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define OST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked out of reset.
`define OST_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define OST_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define OST_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/core/ost_pkg.sv @@
// Types and constants of the ordered set table.
`timescale 1ns / 1ps
package ost_pkg;

   localparam int OST_CAPACITY   = 128;
   localparam int OST_KEY_WIDTH  = 32;
   localparam int OST_GROUP_SIZE = 16;
   localparam int OST_LOC_W      = $clog2(OST_GROUP_SIZE);

   // Request codes
   localparam logic [1:0] OP_ADD  = 2'd0;
   localparam logic [1:0] OP_DEL  = 2'd1;
   localparam logic [1:0] OP_FIND = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_PRESENT = 2'd2;
   localparam logic [1:0] ST_MISSING = 2'd3;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] key;
   } ost_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [6:0] slot;
   } ost_rsp_type;

   typedef struct packed {
      logic compare;
      logic write;
      logic shift;
   } ost_cell_ctl_type;

endpackage

@@ rtl/core/ost_cell.sv @@
// One table cell: holds an entry, matches it against the key, shifts down on delete.
`timescale 1ns / 1ps
module ost_cell import ost_pkg::*; #(
   parameter int CAPACITY  = OST_CAPACITY,
   parameter int KEY_WIDTH = OST_KEY_WIDTH,
   parameter int INDEX     = 0,
   localparam int IDX_W    = $clog2(CAPACITY),
   localparam int OCC_W    = $clog2(CAPACITY + 1)
) (
   input  logic                 clock,
   input  ost_cell_ctl_type     ctl,
   input  logic [KEY_WIDTH-1:0] key,
   input  logic [OCC_W-1:0]     occ,
   input  logic [IDX_W-1:0]     pos,
   input  logic [KEY_WIDTH-1:0] upper_entry,
   output logic [KEY_WIDTH-1:0] entry,
   output logic                 hit
);

   logic [KEY_WIDTH-1:0] entry_ff, entry_in;
   logic                 hit_ff, hit_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.write && (occ == OCC_W'(INDEX))) begin
         entry_in = key;
      end else if (ctl.shift && (IDX_W'(INDEX) >= pos)) begin
         entry_in = upper_entry;  // close the gap left by the deleted key
      end
   end

   // Only slots below the fill count take part in the match.
   assign hit_in = ctl.compare ? ((entry_ff == key) && (OCC_W'(INDEX) < occ)) : hit_ff;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

@@ rtl/core/ost_encoder.sv @@
// Two-stage registered encoder turning the one-hot hit row into a slot index.
`timescale 1ns / 1ps
module ost_encoder import ost_pkg::*; #(
   parameter int CAPACITY = OST_CAPACITY,
   localparam int IDX_W   = $clog2(CAPACITY)
) (
   input  logic                clock,
   input  logic [CAPACITY-1:0] hits,
   output logic                found,
   output logic [IDX_W-1:0]    pos
);

   localparam int NG = (CAPACITY + OST_GROUP_SIZE - 1) / OST_GROUP_SIZE;

   logic [NG*OST_GROUP_SIZE-1:0] hit_pad;
   logic [NG-1:0]                grp_any_ff, grp_any_in;
   logic [OST_LOC_W-1:0]         grp_idx_ff [NG];
   logic [OST_LOC_W-1:0]         grp_idx_in [NG];
   logic                         found_ff, found_in;
   logic [IDX_W-1:0]             pos_ff, pos_in;

   always_comb begin
      hit_pad                = '0;
      hit_pad[CAPACITY-1:0]  = hits;
   end

   // Stage 1: local index within each group of cells
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_any_in[g] = |hit_pad[g*OST_GROUP_SIZE +: OST_GROUP_SIZE];
         grp_idx_in[g] = '0;
         for (int j = 0; j < OST_GROUP_SIZE; j++) begin
            if (hit_pad[g*OST_GROUP_SIZE + j]) begin
               grp_idx_in[g] = grp_idx_in[g] | OST_LOC_W'(j);
            end
         end
      end
   end

   // Stage 2: merge groups; at most one group hits
   always_comb begin
      found_in = |grp_any_ff;
      pos_in   = '0;
      for (int g = 0; g < NG; g++) begin
         if (grp_any_ff[g]) begin
            pos_in = pos_in | IDX_W'(g * OST_GROUP_SIZE) | IDX_W'(grp_idx_ff[g]);
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_any_ff <= grp_any_in;
      grp_idx_ff <= grp_idx_in;
      found_ff   <= found_in;
      pos_ff     <= pos_in;
   end

   assign found = found_ff;
   assign pos   = pos_ff;

endmodule

@@ rtl/core/ordered_set_table.sv @@
// Ordered set table: distinct keys kept in insertion order in a row of cells.
// Usage:
//  - req channel (req_valid/req_ready/req_data) carries one transaction per
//    request: req_type selects add, delete or find, key is the key.
//  - rsp channel (rsp_valid/rsp_ready/rsp_data) returns one transaction per
//    request with a status and the slot the key was added at, deleted from
//    or found in (slot is 0 unless status is ok).
//  - Sequencing: the block takes one request at a time; a new request is
//    accepted only once the previous one has passed the update step. The
//    sequence is compare -> two encoder stages -> update: every cell
//    compares against the key, then the one-hot hit row is encoded in two
//    registered stages before the table is written.
//  - Delete shifts all later cells down one slot in the same update cycle.
//  - If rsp_ready is low, the finished response waits in the output
//    register; the next request may still be accepted and is worked up to
//    the update step, which holds until the output register frees.
//  - Reset empties the table (fill count to zero); entry contents are not
//    cleared and are never read above the fill count.
`timescale 1ns / 1ps
`include "ordered_set_table_assert.svh"
module ordered_set_table import ost_pkg::*; #(
   parameter int CAPACITY  = OST_CAPACITY,
   parameter int KEY_WIDTH = OST_KEY_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ost_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ost_rsp_type rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int OCC_W = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMP,
      S_ENC1,
      S_ENC2,
      S_EXEC
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [OCC_W-1:0]     occ_ff, occ_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ost_rsp_type          rsp_data_ff, rsp_data_in;

   logic [KEY_WIDTH+31:0] key_wide;
   logic                  req_fire;
   logic                  exec_fire;
   logic                  found;
   logic [IDX_W-1:0]      pos;
   logic                  full;
   logic                  do_write, do_shift;
   logic [1:0]            status;
   logic [IDX_W-1:0]      slot_idx;
   logic [IDX_W+6:0]      slot_wide;

   logic [CAPACITY-1:0]   hits;
   logic [KEY_WIDTH-1:0]  entries [CAPACITY];
   ost_cell_ctl_type      cell_ctl;

   // Keys compare on their low KEY_WIDTH bits, zero-extended past 32.
   assign key_wide = {{KEY_WIDTH{1'b0}}, req_data.key};

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign exec_fire = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign full      = (occ_ff == OCC_W'(CAPACITY));

   // Outcome of the request, valid in the update state
   always_comb begin
      status   = ST_MISSING;
      slot_idx = '0;
      do_write = 1'b0;
      do_shift = 1'b0;
      case (op_ff)
         OP_ADD: begin
            if (found) begin
               status = ST_PRESENT;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               status   = ST_OK;
               slot_idx = occ_ff[IDX_W-1:0];
               do_write = 1'b1;
            end
         end
         OP_DEL: begin
            if (found) begin
               status   = ST_OK;
               slot_idx = pos;
               do_shift = 1'b1;
            end
         end
         OP_FIND: begin
            if (found) begin
               status   = ST_OK;
               slot_idx = pos;
            end
         end
         default: begin
            status = ST_MISSING;
         end
      endcase
   end

   assign slot_wide = {7'b0, slot_idx};

   assign cell_ctl.compare = (state_ff == S_CMP);
   assign cell_ctl.write   = exec_fire && do_write;
   assign cell_ctl.shift   = exec_fire && do_shift;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_data.req_type;
               key_in   = key_wide[KEY_WIDTH-1:0];
               state_in = S_CMP;
            end
         end
         S_CMP:  state_in = S_ENC1;
         S_ENC1: state_in = S_ENC2;
         S_ENC2: state_in = S_EXEC;
         S_EXEC: begin
            if (exec_fire) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = status;
               rsp_data_in.slot   = slot_wide[6:0];
               if (do_write) begin
                  occ_in = occ_ff + OCC_W'(1);
               end else if (do_shift) begin
                  occ_in = occ_ff - OCC_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Row of cells; each shifts from its upper neighbor on delete, the last keeps its own entry.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_WIDTH-1:0] upper;
      if (i == CAPACITY - 1) begin : g_last
         assign upper = entries[i];
      end else begin : g_mid
         assign upper = entries[i+1];
      end
      ost_cell #(
         .CAPACITY  (CAPACITY),
         .KEY_WIDTH (KEY_WIDTH),
         .INDEX     (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .key         (key_ff),
         .occ         (occ_ff),
         .pos         (pos),
         .upper_entry (upper),
         .entry       (entries[i]),
         .hit         (hits[i])
      );
   end

   ost_encoder #(
      .CAPACITY (CAPACITY)
   ) u_encoder (
      .clock (clock),
      .hits  (hits),
      .found (found),
      .pos   (pos)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Keys are distinct, so at most one cell below the fill count matches.
   `OST_ASSERT_IMP(a_hits_onehot, clock, reset, state_ff == S_ENC1, $onehot0(hits),
      "more than one cell matched the key")
   `OST_ASSERT_IMP(a_occ_bound, clock, reset, 1'b1, occ_ff <= OCC_W'(CAPACITY),
      "fill count exceeds capacity")
   `OST_ASSERT_NXT(a_del_count, clock, reset, exec_fire && do_shift,
      occ_ff == $past(occ_ff) - OCC_W'(1), "delete did not drop the fill count")
   `OST_ASSERT_IMP(a_slot_zero, clock, reset, rsp_valid_ff && (rsp_data_ff.status != ST_OK),
      rsp_data_ff.slot == 7'd0, "slot not zero on a failed request")

endmodule
